// ----- design/rrd_pkg.sv -----
// ----------------------------------------------------------------------------
// rrd_pkg
// Shared widths and carried types for the reflect/refract direction pipeline.
// ----------------------------------------------------------------------------
package rrd_pkg;

  // Q2.14 direction component and Q3.12 index widths
  localparam int DW    = 16;
  localparam int IW    = 15;
  localparam int FRAC  = 14;
  localparam int IFRAC = 12;

  // Wide vector width: mirror vector and refracted sum before normalizing
  localparam int RW  = 50;
  // Tangent magnitude after the Q42 -> Q28 cut
  localparam int SMW = 33;
  // Scaled tangent magnitude and number of quotient bits of the index divider
  localparam int QW  = 45;

  // Square root steps: refraction cosine and normalizer length
  localparam int RSQ = 29;
  localparam int NSQ = 31;
  // Quotient bits of the normalizer divider
  localparam int NQB = 15;

  typedef logic [2:0][RW-1:0] vec3_t;
  typedef logic [2:0][DW-1:0] dir3_t;

  // Side data that rides along the refraction stages
  typedef struct packed {
    vec3_t      refl;
    dir3_t      nrm;
    logic [2:0] sneg;
    logic       dn_neg;
    logic       rvalid;
  } side_t;

endpackage

// ----- design/rrd_norm.sv -----
// ----------------------------------------------------------------------------
// rrd_norm
// Pipelined vector normalizer: pre-shift, sum of squares, digit-serial square
// root one step per stage, then a restoring divide one quotient bit per stage.
// ----------------------------------------------------------------------------
module rrd_norm (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  logic           in_tag,
  input  rrd_pkg::vec3_t in_vec,
  output logic           out_valid,
  output logic           out_tag,
  output rrd_pkg::dir3_t out_res
);

  localparam int RW   = rrd_pkg::RW;
  localparam int DW   = rrd_pkg::DW;
  localparam int SW   = 30;
  localparam int SHW  = $clog2(RW - SW + 1);
  localparam int NSQ  = rrd_pkg::NSQ;
  localparam int SQW  = 2 * NSQ + 1;
  localparam int LW   = NSQ;
  localparam int DENW = LW + 1;
  localparam int NQB  = rrd_pkg::NQB;
  localparam int NUMW = SW + NQB + 1;
  localparam int CW   = DENW + NQB;
  localparam int SCL  = rrd_pkg::FRAC + 1;

  // Stage 1: sign and magnitude
  logic                 v1_r, t1_r;
  logic [2:0][RW-1:0]   mag1_r;
  logic [2:0]           neg1_r;
  logic [2:0][RW-1:0]   mag_c;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag_c[k] = in_vec[k][RW-1] ? (~in_vec[k] + RW'(1)) : in_vec[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r   <= in_tag;
      mag1_r <= mag_c;
      for (int k = 0; k < 3; k++) begin
        neg1_r[k] <= in_vec[k][RW-1];
      end
    end
  end

  // Stage 2: shift count from the highest set bit of any component
  logic                 v2_r, t2_r;
  logic [2:0][RW-1:0]   mag2_r;
  logic [2:0]           neg2_r;
  logic [SHW-1:0]       sh2_r;
  logic [RW-1:0]        orv_c;
  logic [SHW-1:0]       sh_c;

  always_comb begin
    orv_c = mag1_r[0] | mag1_r[1] | mag1_r[2];
    sh_c  = '0;
    for (int i = SW; i < RW; i++) begin
      if (orv_c[i]) sh_c = SHW'(i - SW + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t2_r   <= t1_r;
      mag2_r <= mag1_r;
      neg2_r <= neg1_r;
      sh2_r  <= sh_c;
    end
  end

  // Stage 3: apply the shift
  logic                 v3_r, t3_r;
  logic [2:0][SW-1:0]   m3_r;
  logic [2:0]           neg3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t3_r   <= t2_r;
      neg3_r <= neg2_r;
      for (int k = 0; k < 3; k++) begin
        m3_r[k] <= SW'(mag2_r[k] >> sh2_r);
      end
    end
  end

  // Stage 4: squares
  logic                   v4_r, t4_r;
  logic [2:0][SW-1:0]     m4_r;
  logic [2:0]             neg4_r;
  logic [2:0][2*SW-1:0]   sq4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t4_r   <= t3_r;
      m4_r   <= m3_r;
      neg4_r <= neg3_r;
      for (int k = 0; k < 3; k++) begin
        sq4_r[k] <= (2*SW)'(m3_r[k]) * (2*SW)'(m3_r[k]);
      end
    end
  end

  // Square root pipeline; entry 0 holds the sum of squares
  logic                 vq_r  [0:NSQ];
  logic                 tq_r  [0:NSQ];
  logic [SQW-1:0]       rem_r [0:NSQ];
  logic [SQW-1:0]       res_r [0:NSQ];
  logic [2:0][SW-1:0]   mq_r  [0:NSQ];
  logic [2:0]           nq_r  [0:NSQ];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vq_r[0] <= 1'b0;
    end else if (en) begin
      vq_r[0] <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tq_r[0]  <= t4_r;
      rem_r[0] <= SQW'(sq4_r[0]) + SQW'(sq4_r[1]) + SQW'(sq4_r[2]);
      res_r[0] <= '0;
      mq_r[0]  <= m4_r;
      nq_r[0]  <= neg4_r;
    end
  end

  for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
    localparam int BP = 2 * (NSQ - 1 - j);
    logic [SQW-1:0] trial_c, rem_c, res_c;

    // Try the next root bit
    always_comb begin
      trial_c = res_r[j] + (SQW'(1) << BP);
      if (rem_r[j] >= trial_c) begin
        rem_c = rem_r[j] - trial_c;
        res_c = (res_r[j] >> 1) + (SQW'(1) << BP);
      end else begin
        rem_c = rem_r[j];
        res_c = res_r[j] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vq_r[j+1] <= 1'b0;
      end else if (en) begin
        vq_r[j+1] <= vq_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tq_r[j+1]  <= tq_r[j];
        rem_r[j+1] <= rem_c;
        res_r[j+1] <= res_c;
        mq_r[j+1]  <= mq_r[j];
        nq_r[j+1]  <= nq_r[j];
      end
    end
  end

  // Divider pipeline; entry 0 holds numerators and doubled length
  logic                   vd_r   [0:NQB];
  logic                   td_r   [0:NQB];
  logic [DENW-1:0]        dden_r [0:NQB];
  logic [2:0][NUMW-1:0]   dnum_r [0:NQB];
  logic [2:0][NQB-1:0]    dq_r   [0:NQB];
  logic [2:0]             dneg_r [0:NQB];
  logic [LW-1:0]          len_c;

  always_comb begin
    len_c = res_r[NSQ][LW-1:0];
    if (len_c == '0) len_c = LW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r[0] <= 1'b0;
    end else if (en) begin
      vd_r[0] <= vq_r[NSQ];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      td_r[0]   <= tq_r[NSQ];
      dden_r[0] <= {len_c, 1'b0};
      dq_r[0]   <= '0;
      dneg_r[0] <= nq_r[NSQ];
      for (int k = 0; k < 3; k++) begin
        dnum_r[0][k] <= (NUMW'(mq_r[NSQ][k]) << SCL) + NUMW'(len_c);
      end
    end
  end

  for (genvar j = 0; j < NQB; j++) begin : g_div
    localparam int QB = NQB - 1 - j;
    logic [2:0][NUMW-1:0] num_c;
    logic [2:0][NQB-1:0]  q_c;
    logic [CW-1:0]        dsh_c, numx_c;

    // Subtract the shifted divisor where it fits
    always_comb begin
      dsh_c = CW'(dden_r[j]) << QB;
      for (int k = 0; k < 3; k++) begin
        numx_c = CW'(dnum_r[j][k]);
        if (numx_c >= dsh_c) begin
          num_c[k] = NUMW'(numx_c - dsh_c);
          q_c[k]   = dq_r[j][k] | (NQB'(1) << QB);
        end else begin
          num_c[k] = dnum_r[j][k];
          q_c[k]   = dq_r[j][k];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vd_r[j+1] <= 1'b0;
      end else if (en) begin
        vd_r[j+1] <= vd_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        td_r[j+1]   <= td_r[j];
        dden_r[j+1] <= dden_r[j];
        dnum_r[j+1] <= num_c;
        dq_r[j+1]   <= q_c;
        dneg_r[j+1] <= dneg_r[j];
      end
    end
  end

  // Restore signs
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      out_res[k] = dneg_r[NQB][k] ? (DW'(0) - DW'(dq_r[NQB][k])) : DW'(dq_r[NQB][k]);
    end
  end

  assign out_valid = vd_r[NQB];
  assign out_tag   = td_r[NQB];

endmodule

// ----- design/reflect_refract_direction.sv -----
// ----------------------------------------------------------------------------
// reflect_refract_direction
// Mirror and refracted ray directions, each normalized to Q2.14.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle unless the pipeline stalls; the depth
// is set by the 45-step index divider, the 29-step cosine square root and the
// 52-stage normalizers.
// Stall: the whole pipeline holds while out_valid is high and out_ready is low.
// Reset: synchronous, active low; clears all valid bits, payload is not reset.
module reflect_refract_direction (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [rrd_pkg::DW-1:0] in_dir_x,
  input  logic signed [rrd_pkg::DW-1:0] in_dir_y,
  input  logic signed [rrd_pkg::DW-1:0] in_dir_z,
  input  logic signed [rrd_pkg::DW-1:0] in_norm_x,
  input  logic signed [rrd_pkg::DW-1:0] in_norm_y,
  input  logic signed [rrd_pkg::DW-1:0] in_norm_z,
  input  logic [rrd_pkg::IW-1:0]      in_refr_index,
  input  logic                        in_transmit_on,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [rrd_pkg::DW-1:0] out_refl_x,
  output logic signed [rrd_pkg::DW-1:0] out_refl_y,
  output logic signed [rrd_pkg::DW-1:0] out_refl_z,
  output logic                        out_refr_valid,
  output logic signed [rrd_pkg::DW-1:0] out_refr_x,
  output logic signed [rrd_pkg::DW-1:0] out_refr_y,
  output logic signed [rrd_pkg::DW-1:0] out_refr_z
);

  localparam int DW    = rrd_pkg::DW;
  localparam int IW    = rrd_pkg::IW;
  localparam int RW    = rrd_pkg::RW;
  localparam int SMW   = rrd_pkg::SMW;
  localparam int QW    = rrd_pkg::QW;
  localparam int FRAC  = rrd_pkg::FRAC;
  localparam int IFRAC = rrd_pkg::IFRAC;
  localparam int RSQ   = rrd_pkg::RSQ;
  localparam int F2    = 2 * FRAC;
  localparam int PW    = 2 * DW;
  localparam int DNW   = PW + 1;
  localparam int DNNW  = DNW + DW;
  localparam int SQDW  = 2 * F2;
  localparam int SDW   = F2 + 1;
  localparam int TPW   = 2 * IW + SDW;
  localparam int LPW   = SMW + IW;
  localparam int DCW   = QW + IW;
  localparam int TSW   = 2 * (F2 + 1);
  localparam int T2W   = TSW + 2;
  localparam int RQW   = 2 * RSQ + 1;
  localparam int CPW   = DW + RSQ + 1;

  logic out_valid_r, en;
  logic out_refr_valid_r;
  rrd_pkg::dir3_t out_refl_r, out_refr_r;

  // Advance everything unless a finished transaction is waiting
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // Stage 1: capture input, a zero index counts as the smallest step
  logic                 s1_v_r, s1_tr_r;
  rrd_pkg::dir3_t       s1_d_r, s1_n_r;
  logic [IW-1:0]        s1_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_d_r   <= {in_dir_z, in_dir_y, in_dir_x};
      s1_n_r   <= {in_norm_z, in_norm_y, in_norm_x};
      s1_idx_r <= (in_refr_index == '0) ? IW'(1) : in_refr_index;
      s1_tr_r  <= in_transmit_on;
    end
  end

  // Stage 2: component products and index squared
  logic                 s2_v_r, s2_tr_r;
  rrd_pkg::dir3_t       s2_d_r, s2_n_r;
  logic [IW-1:0]        s2_idx_r;
  logic [2*IW-1:0]      s2_idx2_r;
  logic [2:0][PW-1:0]   s2_p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_d_r    <= s1_d_r;
      s2_n_r    <= s1_n_r;
      s2_idx_r  <= s1_idx_r;
      s2_tr_r   <= s1_tr_r;
      s2_idx2_r <= (2*IW)'(s1_idx_r) * (2*IW)'(s1_idx_r);
      for (int k = 0; k < 3; k++) begin
        s2_p_r[k] <= PW'($signed(s1_d_r[k]) * $signed(s1_n_r[k]));
      end
    end
  end

  // Stage 3: dot product d.N in Q5.28
  logic                    s3_v_r, s3_tr_r;
  rrd_pkg::dir3_t          s3_d_r, s3_n_r;
  logic [IW-1:0]           s3_idx_r;
  logic [2*IW-1:0]         s3_idx2_r;
  logic signed [DNW-1:0]   s3_dn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_d_r    <= s2_d_r;
      s3_n_r    <= s2_n_r;
      s3_idx_r  <= s2_idx_r;
      s3_idx2_r <= s2_idx2_r;
      s3_tr_r   <= s2_tr_r;
      s3_dn_r   <= DNW'($signed(s2_p_r[0])) + DNW'($signed(s2_p_r[1]))
                 + DNW'($signed(s2_p_r[2]));
    end
  end

  // Stage 4: (d.N)N, (d.N)^2 and sign flags
  logic                   s4_v_r, s4_tr_r;
  rrd_pkg::dir3_t         s4_d_r, s4_n_r;
  logic [IW-1:0]          s4_idx_r;
  logic [2*IW-1:0]        s4_idx2_r;
  logic [2:0][DNNW-1:0]   s4_dnn_r;
  logic [SQDW-1:0]        s4_dnsq_r;
  logic                   s4_small_r, s4_neg_r, s4_nz_r;
  logic [2:0][DNNW-1:0]   dnn_c;
  logic signed [DNNW-1:0] dne_c, ne_c;

  always_comb begin
    dne_c = DNNW'(s3_dn_r);
    for (int k = 0; k < 3; k++) begin
      ne_c     = DNNW'($signed(s3_n_r[k]));
      dnn_c[k] = dne_c * ne_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_d_r     <= s3_d_r;
      s4_n_r     <= s3_n_r;
      s4_idx_r   <= s3_idx_r;
      s4_idx2_r  <= s3_idx2_r;
      s4_tr_r    <= s3_tr_r;
      s4_dnn_r   <= dnn_c;
      s4_dnsq_r  <= SQDW'(s3_dn_r[F2-1:0]) * SQDW'(s3_dn_r[F2-1:0]);
      s4_neg_r   <= s3_dn_r[DNW-1];
      s4_nz_r    <= (s3_dn_r != '0);
      s4_small_r <= !s3_dn_r[DNW-1] && (s3_dn_r != '0) && (s3_dn_r[DNW-2:F2] == '0);
    end
  end

  // Stage 5: mirror vector, tangent cut to Q28, TIR term 1 - c^2
  logic                   s5_v_r, s5_tr_r;
  rrd_pkg::vec3_t         s5_refl_r;
  rrd_pkg::dir3_t         s5_n_r;
  logic [IW-1:0]          s5_idx_r;
  logic [2*IW-1:0]        s5_idx2_r;
  logic [2:0][SMW-1:0]    s5_sm_r;
  logic [2:0]             s5_sn_r;
  logic [SDW-1:0]         s5_sd_r;
  logic                   s5_small_r, s5_neg_r, s5_nz_r;
  rrd_pkg::vec3_t         refl_c;
  logic [2:0][SMW-1:0]    sm_c;
  logic [2:0]             sn_c;
  logic signed [RW-1:0]   dsh_c, dnne_c, tan_c;
  logic [RW-1:0]          tanm_c;
  logic [SQDW:0]          sdf_c;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dsh_c     = RW'($signed(s4_d_r[k])) <<< F2;
      dnne_c    = RW'($signed(s4_dnn_r[k]));
      refl_c[k] = dsh_c - (dnne_c <<< 1);
      tan_c     = dsh_c - dnne_c;
      tanm_c    = tan_c[RW-1] ? RW'(-tan_c) : RW'(tan_c);
      sm_c[k]   = tanm_c[FRAC +: SMW];
      sn_c[k]   = tan_c[RW-1];
    end
    sdf_c = ((SQDW+1)'(1) << SQDW) - (SQDW+1)'(s4_dnsq_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (en) begin
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_refl_r  <= refl_c;
      s5_n_r     <= s4_n_r;
      s5_idx_r   <= s4_idx_r;
      s5_idx2_r  <= s4_idx2_r;
      s5_tr_r    <= s4_tr_r;
      s5_sm_r    <= sm_c;
      s5_sn_r    <= sn_c;
      s5_sd_r    <= sdf_c[SQDW:F2];
      s5_small_r <= s4_small_r;
      s5_neg_r   <= s4_neg_r;
      s5_nz_r    <= s4_nz_r;
    end
  end

  // Stage 6 (divider entry): TIR test, refraction valid, leaving-side scale
  logic                   dv_r   [0:QW];
  logic                   dskp_r [0:QW];
  logic [IW-1:0]          didx_r [0:QW];
  logic [2:0][QW-1:0]     dnum_r [0:QW];
  logic [2:0][QW-1:0]     dq_r   [0:QW];
  rrd_pkg::side_t         dside_r[0:QW];
  logic [TPW-1:0]         tirp_c;
  logic                   tir_c;
  logic [LPW-1:0]         lp_c;
  logic [2:0][QW-1:0]     lq_c, n0_c;
  rrd_pkg::side_t         side_c;

  always_comb begin
    tirp_c = TPW'(s5_idx2_r) * TPW'(s5_sd_r);
    tir_c  = s5_small_r && (tirp_c > (TPW'(1) << (2 * IFRAC + F2)));
    for (int k = 0; k < 3; k++) begin
      lp_c    = LPW'(s5_sm_r[k]) * LPW'(s5_idx_r);
      lq_c[k] = s5_neg_r ? '0 : QW'(lp_c[LPW-1:IFRAC]);
      n0_c[k] = QW'(s5_sm_r[k]) << IFRAC;
    end
    side_c.refl   = s5_refl_r;
    side_c.nrm    = s5_n_r;
    side_c.sneg   = s5_sn_r;
    side_c.dn_neg = s5_neg_r;
    side_c.rvalid = s5_tr_r && s5_nz_r && !tir_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dskp_r[0]  <= !s5_neg_r;
      didx_r[0]  <= s5_idx_r;
      dnum_r[0]  <= n0_c;
      dq_r[0]    <= lq_c;
      dside_r[0] <= side_c;
    end
  end

  // Entering side: tangent * 4096 / index, one quotient bit per stage
  for (genvar j = 0; j < QW; j++) begin : g_idiv
    localparam int QB = QW - 1 - j;
    logic [2:0][QW-1:0] num_c, q_c;
    logic [DCW-1:0]     dsh_c, numx_c;

    always_comb begin
      dsh_c = DCW'(didx_r[j]) << QB;
      for (int k = 0; k < 3; k++) begin
        numx_c = DCW'(dnum_r[j][k]);
        if (!dskp_r[j] && (numx_c >= dsh_c)) begin
          num_c[k] = QW'(numx_c - dsh_c);
          q_c[k]   = dq_r[j][k] | (QW'(1) << QB);
        end else begin
          num_c[k] = dnum_r[j][k];
          q_c[k]   = dq_r[j][k];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j+1] <= 1'b0;
      end else if (en) begin
        dv_r[j+1] <= dv_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dskp_r[j+1]  <= dskp_r[j];
        didx_r[j+1]  <= didx_r[j];
        dnum_r[j+1]  <= num_c;
        dq_r[j+1]    <= q_c;
        dside_r[j+1] <= dside_r[j];
      end
    end
  end

  // Stage H: long-tangent flag and squared components
  logic                   h_v_r, h_big_r;
  logic [2:0][QW-1:0]     h_q_r;
  logic [2:0][TSW-1:0]    h_sq_r;
  rrd_pkg::side_t         h_side_r;
  logic                   big_c;

  always_comb begin
    big_c = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (dq_r[QW][k] > (QW'(1) << F2)) big_c = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_v_r <= 1'b0;
    end else if (en) begin
      h_v_r <= dv_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_q_r    <= dq_r[QW];
      h_big_r  <= big_c;
      h_side_r <= dside_r[QW];
      for (int k = 0; k < 3; k++) begin
        h_sq_r[k] <= TSW'(dq_r[QW][k][F2:0]) * TSW'(dq_r[QW][k][F2:0]);
      end
    end
  end

  // Stage I (root entry): t^2, zeroed when too long, radicand 1 - t^2
  logic                 rv_r   [0:RSQ];
  logic [RQW-1:0]       rrem_r [0:RSQ];
  logic [RQW-1:0]       rres_r [0:RSQ];
  logic [2:0][QW-1:0]   rq_r   [0:RSQ];
  rrd_pkg::side_t       rside_r[0:RSQ];
  logic [T2W-1:0]       t2_c;
  logic                 t2z_c;

  always_comb begin
    t2_c  = T2W'(h_sq_r[0]) + T2W'(h_sq_r[1]) + T2W'(h_sq_r[2]);
    t2z_c = h_big_r || (t2_c > (T2W'(1) << SQDW));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r[0] <= 1'b0;
    end else if (en) begin
      rv_r[0] <= h_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rrem_r[0]  <= (RQW'(1) << SQDW) - (t2z_c ? RQW'(0) : RQW'(t2_c));
      rres_r[0]  <= '0;
      rq_r[0]    <= h_q_r;
      rside_r[0] <= h_side_r;
    end
  end

  // Cosine square root, one result bit per stage
  for (genvar j = 0; j < RSQ; j++) begin : g_rsqrt
    localparam int BP = 2 * (RSQ - 1 - j);
    logic [RQW-1:0] trial_c, rem_c, res_c;

    always_comb begin
      trial_c = rres_r[j] + (RQW'(1) << BP);
      if (rrem_r[j] >= trial_c) begin
        rem_c = rrem_r[j] - trial_c;
        res_c = (rres_r[j] >> 1) + (RQW'(1) << BP);
      end else begin
        rem_c = rrem_r[j];
        res_c = rres_r[j] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rv_r[j+1] <= 1'b0;
      end else if (en) begin
        rv_r[j+1] <= rv_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rrem_r[j+1]  <= rem_c;
        rres_r[j+1]  <= res_c;
        rq_r[j+1]    <= rq_r[j];
        rside_r[j+1] <= rside_r[j];
      end
    end
  end

  // Stage J: N * cos
  logic                   j_v_r;
  logic [2:0][CPW-1:0]    j_cp_r;
  logic [2:0][QW-1:0]     j_q_r;
  rrd_pkg::side_t         j_side_r;
  logic [2:0][CPW-1:0]    cp_c;
  logic signed [CPW-1:0]  cne_c, cte_c;

  always_comb begin
    cte_c = CPW'(rres_r[RSQ][RSQ-1:0]);
    for (int k = 0; k < 3; k++) begin
      cne_c   = CPW'($signed(rside_r[RSQ].nrm[k]));
      cp_c[k] = cne_c * cte_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_v_r <= 1'b0;
    end else if (en) begin
      j_v_r <= rv_r[RSQ];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      j_cp_r   <= cp_c;
      j_q_r    <= rq_r[RSQ];
      j_side_r <= rside_r[RSQ];
    end
  end

  // Stage K: refracted sum tangent +- normal part, zero when invalid
  logic                   k_v_r, k_rv_r;
  rrd_pkg::vec3_t         k_sum_r, k_refl_r;
  rrd_pkg::vec3_t         sum_c;
  logic signed [CPW-1:0]  cps_c;
  logic [CPW-1:0]         cpm_c;
  logic signed [RW-1:0]   cv_c, st_c;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cps_c = $signed(j_cp_r[k]);
      cpm_c = cps_c[CPW-1] ? CPW'(-cps_c) : CPW'(cps_c);
      cv_c  = RW'(cpm_c >> FRAC);
      if (cps_c[CPW-1] ^ j_side_r.dn_neg) cv_c = -cv_c;
      st_c  = RW'(j_q_r[k]);
      if (j_side_r.sneg[k]) st_c = -st_c;
      sum_c[k] = j_side_r.rvalid ? RW'(st_c + cv_c) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_v_r <= 1'b0;
    end else if (en) begin
      k_v_r <= j_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k_sum_r  <= sum_c;
      k_refl_r <= j_side_r.refl;
      k_rv_r   <= j_side_r.rvalid;
    end
  end

  // Normalize both directions in lockstep
  logic            nrl_v, nrl_t, nrr_v, nrr_t;
  rrd_pkg::dir3_t  nrl_res, nrr_res;

  rrd_norm u_norm_refl (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (k_v_r),
    .in_tag    (k_rv_r),
    .in_vec    (k_refl_r),
    .out_valid (nrl_v),
    .out_tag   (nrl_t),
    .out_res   (nrl_res)
  );

  rrd_norm u_norm_refr (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (k_v_r),
    .in_tag    (k_rv_r),
    .in_vec    (k_sum_r),
    .out_valid (nrr_v),
    .out_tag   (nrr_t),
    .out_res   (nrr_res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= nrl_v && nrr_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_refl_r       <= nrl_res;
      out_refr_r       <= nrr_t ? nrr_res : '0;
      out_refr_valid_r <= nrl_t && nrr_t;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_refl_x     = out_refl_r[0];
  assign out_refl_y     = out_refl_r[1];
  assign out_refl_z     = out_refl_r[2];
  assign out_refr_valid = out_refr_valid_r;
  assign out_refr_x     = out_refr_r[0];
  assign out_refr_y     = out_refr_r[1];
  assign out_refr_z     = out_refr_r[2];

endmodule
